[sv/lgs_pkg.sv]
package lgs_pkg;

  // Request kinds as they arrive on the kind port
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Neighbour counts of rule B3/S23
  localparam logic [3:0] SURVIVE_LOW = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  localparam int unsigned ROW_PORT_W = 16;
  localparam int unsigned INDEX_W    = 4;

  // Classified request held in the queue between front and back
  typedef struct packed {
    logic [1:0]            op;
    logic                  in_range;
    logic [INDEX_W-1:0]    idx;
    logic [ROW_PORT_W-1:0] cells;
  } cmd_t;

endpackage

[sv/lgs_ram.sv]
module lgs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lgs_front.sv]
module lgs_front #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        kind,
  input  logic [lgs_pkg::INDEX_W-1:0]       row_index,
  input  logic [lgs_pkg::ROW_PORT_W-1:0]    row_cells,
  output logic                              q_valid,
  output lgs_pkg::cmd_t                     q_cmd,
  input  logic                              q_pop
);

  import lgs_pkg::*;

  localparam logic [6:0] GRID_ROWS = 7'(GRID_SIZE);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       in_range;
  logic       push;
  cmd_t       cmd_in;

  assign busy     = (count == 2'd2);
  assign in_range = ({3'b000, row_index} < GRID_ROWS);

  // Drop unused kinds and writes beyond the grid; out-of-range reads still answer zero
  always_comb begin
    cmd_in.op       = kind;
    cmd_in.in_range = in_range;
    cmd_in.idx      = row_index;
    cmd_in.cells    = row_cells;
    push = start && !busy;
    if (kind != KIND_WRITE && kind != KIND_ADVANCE && kind != KIND_READ) begin
      push = 1'b0;
    end
    if (kind == KIND_WRITE && !in_range) begin
      push = 1'b0;
    end
  end

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 2'd1;
    end else if (!push && q_pop) begin
      count_next = count - 2'd1;
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_cmd   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

endmodule

[sv/lgs_back.sv]
module lgs_back #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  lgs_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           strobe,
  output logic [lgs_pkg::ROW_PORT_W-1:0] row_value
);

  import lgs_pkg::*;

  localparam int unsigned AW = $clog2(GRID_SIZE);
  localparam logic [AW-1:0] LAST_ROW = AW'(GRID_SIZE - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_TOP   = 3'd2;
  localparam logic [2:0] ST_FIRST = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [AW-1:0]        row;
  logic [AW:0]          row_ahead;
  logic [GRID_SIZE-1:0] first;
  logic [GRID_SIZE-1:0] prior;
  logic [GRID_SIZE-1:0] here;
  logic [GRID_SIZE-1:0] below;
  logic [GRID_SIZE-1:0] new_row;
  logic [GRID_SIZE-1:0] valid;
  logic                 valid_q;
  logic                 read_hit;
  logic [GRID_SIZE-1:0] rdata;
  logic [GRID_SIZE-1:0] rrow;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [GRID_SIZE-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        cmd_addr;
  logic [AW+INDEX_W-1:0]         idx_ext;
  logic [GRID_SIZE+ROW_PORT_W-1:0] cells_ext;
  logic [GRID_SIZE+ROW_PORT_W-1:0] rrow_ext;

  lgs_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idx_ext   = {{AW{1'b0}}, q_cmd.idx};
  assign cmd_addr  = idx_ext[AW-1:0];
  assign cells_ext = {{GRID_SIZE{1'b0}}, q_cmd.cells};
  // Rows never written since reset read as dead
  assign rrow      = valid_q ? rdata : '0;
  assign rrow_ext  = {{ROW_PORT_W{1'b0}}, rrow};
  assign row_ahead = {1'b0, row} + (AW + 1)'(2);
  assign below     = (row == LAST_ROW) ? first : rrow;

  // One generation of one row from the old rows above, here and below
  always_comb begin
    logic [3:0] n;
    int         l;
    int         r;
    n = '0;
    new_row = '0;
    for (int c = 0; c < GRID_SIZE; c++) begin
      l = (c == 0) ? GRID_SIZE - 1 : c - 1;
      r = (c == GRID_SIZE - 1) ? 0 : c + 1;
      n = 4'(prior[l]) + 4'(prior[c]) + 4'(prior[r])
        + 4'(here[l]) + 4'(here[r])
        + 4'(below[l]) + 4'(below[c]) + 4'(below[r]);
      new_row[c] = here[c] ? (n == SURVIVE_LOW || n == BIRTH_COUNT) : (n == BIRTH_COUNT);
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = row;
    wdata      = new_row;
    raddr      = '0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            KIND_WRITE: begin
              we    = 1'b1;
              waddr = cmd_addr;
              wdata = cells_ext[GRID_SIZE-1:0];
            end
            KIND_READ: begin
              raddr      = cmd_addr;
              state_next = ST_READ;
            end
            KIND_ADVANCE: begin
              raddr      = LAST_ROW;
              state_next = ST_TOP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_TOP: begin
        raddr      = '0;
        state_next = ST_FIRST;
      end
      ST_FIRST: begin
        raddr      = AW'(1);
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        we    = 1'b1;
        raddr = row_ahead[AW-1:0];
        if (row == LAST_ROW) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= '0;
      valid_q <= 1'b0;
      strobe  <= 1'b0;
      row     <= '0;
    end else begin
      state   <= state_next;
      valid_q <= valid[raddr];
      strobe  <= (state == ST_READ);
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (state == ST_FIRST) begin
        row <= '0;
      end else if (state == ST_SWEEP) begin
        row <= (row == LAST_ROW) ? '0 : row + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      read_hit <= q_cmd.in_range;
    end
    if (state == ST_READ) begin
      row_value <= read_hit ? rrow_ext[ROW_PORT_W-1:0] : '0;
    end
    if (state == ST_TOP) begin
      prior <= rrow;
    end
    if (state == ST_FIRST) begin
      first <= rrow;
      here  <= rrow;
    end
    if (state == ST_SWEEP) begin
      // Shift the window down one row
      prior <= here;
      here  <= rrow;
    end
  end

endmodule

[sv/life_grid_generation_step.sv]
// Toroidal Game of Life grid, rule B3/S23, GRID_SIZE x GRID_SIZE one-bit cells.
// Requests: drive kind, row_index and row_cells with start high; a request is
// taken at a rising edge where start is high and busy is low. kind selects a
// row write, a one-generation advance or a row read; kind 3 is taken and dropped.
// Results: only a read answers. row_value is shown for one cycle with strobe
// high; strobe rises once the request has left the queue and passed the read
// state. The receiver cannot hold a result off, so none is ever stalled.
// A write ends as it is popped, a read passes the read state, and an advance reads
// the last row and row 0, then sweeps, paced by the grid memory's single read
// port, which the sweep walks one row a cycle. A two-entry request queue sits in
// front, so busy rises only once two requests wait behind the one at work.
// Reset: all cells read as dead (per-row valid bits clear at once), the queue
// empties and the block is ready in the next cycle.
module life_grid_generation_step #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     kind,
  input  logic [lgs_pkg::INDEX_W-1:0]    row_index,
  input  logic [lgs_pkg::ROW_PORT_W-1:0] row_cells,
  output logic                           strobe,
  output logic [lgs_pkg::ROW_PORT_W-1:0] row_value
);

  import lgs_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  lgs_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .row_index (row_index),
    .row_cells (row_cells),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  lgs_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .strobe    (strobe),
    .row_value (row_value)
  );

endmodule

[tb/tb_life_grid_generation_step.sv]
module tb_life_grid_generation_step;
  import lgs_pkg::*;

  localparam int unsigned GRID        = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = GRID + 12;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            kind;
  logic [INDEX_W-1:0]    row_index;
  logic [ROW_PORT_W-1:0] row_cells;
  logic                  strobe;
  logic [ROW_PORT_W-1:0] row_value;

  // Model copy of the board and the rows that reads are still owed
  logic [GRID-1:0]       board [GRID];
  logic [ROW_PORT_W-1:0] pending_rows [$];
  int unsigned           error_count = 0;
  int unsigned           cycle_count = 0;
  int unsigned           idle_pct = 0;

  life_grid_generation_step #(.GRID_SIZE(GRID)) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .row_index (row_index),
    .row_cells (row_cells),
    .strobe    (strobe),
    .row_value (row_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reads outstanding",
               cycle_count, pending_rows.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [ROW_PORT_W-1:0] got,
                                 input logic [ROW_PORT_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned live_neighbours(input int unsigned r, input int unsigned c);
    int unsigned n;
    int unsigned rr;
    int unsigned cc;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          rr = (r + GRID + dr) % GRID;
          cc = (c + GRID + dc) % GRID;
          n += 32'(board[rr][cc]);
        end
      end
    end
    return n;
  endfunction

  // Compute every new cell from the old board before committing any row
  task automatic step_generation();
    logic [GRID-1:0] next_board [GRID];
    int unsigned n;
    for (int unsigned r = 0; r < GRID; r++) begin
      for (int unsigned c = 0; c < GRID; c++) begin
        n = live_neighbours(r, c);
        if (board[r][c])
          next_board[r][c] = (n == SURVIVE_LOW) || (n == BIRTH_COUNT);
        else
          next_board[r][c] = (n == BIRTH_COUNT);
      end
    end
    for (int unsigned r = 0; r < GRID; r++) board[r] = next_board[r];
  endtask

  task automatic apply_request(input logic [1:0] k, input logic [INDEX_W-1:0] idx,
                               input logic [ROW_PORT_W-1:0] cells);
    logic [ROW_PORT_W-1:0] row_out;
    case (k)
      KIND_WRITE: begin
        if (idx < GRID) board[idx] = cells[GRID-1:0];
      end
      KIND_ADVANCE: begin
        step_generation();
      end
      KIND_READ: begin
        row_out = '0;
        if (idx < GRID) row_out[GRID-1:0] = board[idx];
        pending_rows.push_back(row_out);
      end
      default: ;
    endcase
  endtask

  // Hold the request until the edge that takes it; leave start high for a follow-on
  task automatic send_request(input logic [1:0] k, input logic [INDEX_W-1:0] idx,
                              input logic [ROW_PORT_W-1:0] cells);
    start     <= 1'b1;
    kind      <= k;
    row_index <= idx;
    row_cells <= cells;
    do @(posedge clk); while (busy !== 1'b0);
    apply_request(k, idx, cells);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, 6));
  endtask

  always @(posedge clk) begin : result_check
    logic [ROW_PORT_W-1:0] want;
    if (rst === 1'b0 && strobe !== 1'b0) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("row with no read waiting", row_value, '0);
      end else begin
        want = pending_rows.pop_front();
        if (strobe !== 1'b1 || row_value !== want)
          report_mismatch("row_value", row_value, want);
      end
    end
  end

  task automatic test_reset_clear();
    send_request(KIND_READ, 4'd0, 16'hFFFF);
    send_request(KIND_READ, 4'd15, 16'h0000);
    send_request(KIND_READ, 4'd7, 16'hA5A5);
  endtask

  // Glider straddling the corner so every wrap direction is used
  task automatic test_glider_wrap();
    send_request(KIND_WRITE, 4'd14, 16'h0001);
    send_request(KIND_WRITE, 4'd15, 16'h0002);
    send_request(KIND_WRITE, 4'd0, 16'h8003);
    send_request(KIND_ADVANCE, 4'd0, 16'h0000);
    send_request(KIND_ADVANCE, 4'd9, 16'hFFFF);
    send_request(KIND_READ, 4'd14, 16'h0000);
    send_request(KIND_READ, 4'd15, 16'h0000);
    send_request(KIND_READ, 4'd0, 16'h0000);
    send_request(KIND_READ, 4'd1, 16'h0000);
  endtask

  task automatic test_row_extremes();
    send_request(KIND_WRITE, 4'd0, 16'hFFFF);
    send_request(KIND_WRITE, 4'd15, 16'hAAAA);
    send_request(KIND_WRITE, 4'd8, 16'h5555);
    send_request(KIND_READ, 4'd0, 16'h0000);
    send_request(KIND_READ, 4'd15, 16'h0000);
    send_request(KIND_READ, 4'd8, 16'h0000);
    send_request(KIND_ADVANCE, 4'd15, 16'h8001);
    send_request(KIND_READ, 4'd0, 16'h0000);
    send_request(KIND_READ, 4'd15, 16'h0000);
    send_request(KIND_READ, 4'd8, 16'h0000);
  endtask

  task automatic test_unused_kind();
    send_request(KIND_UNUSED, 4'd0, 16'h1234);
    send_request(KIND_READ, 4'd0, 16'h0000);
    idle_cycles(1);
  endtask

  task automatic test_random_mix(input int unsigned count, input int unsigned pct);
    int unsigned sent;
    int unsigned pick;
    logic [1:0] k;
    logic [ROW_PORT_W-1:0] cells;
    idle_pct = pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 35)      k = KIND_WRITE;
      else if (pick < 55) k = KIND_ADVANCE;
      else if (pick < 95) k = KIND_READ;
      else                k = KIND_UNUSED;
      case ($urandom_range(3))
        0:       cells = 16'($urandom() & $urandom());
        1:       cells = 16'($urandom() | $urandom());
        2:       cells = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default: cells = 16'($urandom());
      endcase
      maybe_idle();
      send_request(k, 4'($urandom_range(GRID - 1)), cells);
      if (k != KIND_UNUSED) sent++;
    end
    idle_cycles(1);
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    kind      <= KIND_WRITE;
    row_index <= '0;
    row_cells <= '0;
    for (int unsigned r = 0; r < GRID; r++) board[r] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_clear();
    test_glider_wrap();
    test_row_extremes();
    test_unused_kind();
    test_random_mix(200, 24);
    test_random_mix(200, 63);
    test_random_mix(200, 0);

    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    while (pending_rows.size() != 0)
      report_mismatch("read never answered", '0, pending_rows.pop_front());

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
